[hdl/pfpr_pkg.sv]
// Package for the page frame pool: sizes, codes, state type and command/status structs.
// Used by every module in hdl; depends on nothing.
package pfpr_pkg;

    localparam int NUM_FRAMES_DEF = 16;
    localparam int PAGE_BITS_DEF  = 24;
    localparam int FILE_BITS_DEF  = 8;

    localparam logic [1:0] ACT_PIN   = 2'd0;
    localparam logic [1:0] ACT_UNPIN = 2'd1;
    localparam logic [1:0] ACT_DIRTY = 2'd2;

    localparam logic [1:0] MODE_LRU   = 2'd0;
    localparam logic [1:0] MODE_CLOCK = 2'd1;
    localparam logic [1:0] MODE_MRU   = 2'd2;

    localparam logic [2:0] ST_HIT     = 3'd0;
    localparam logic [2:0] ST_FREE    = 3'd1;
    localparam logic [2:0] ST_EVICT   = 3'd2;
    localparam logic [2:0] ST_PINNED  = 3'd3;
    localparam logic [2:0] ST_ABSENT  = 3'd4;
    localparam logic [2:0] ST_DONE    = 3'd5;

    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_FRAMES = 2'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_CLOCK,
        S_APPLY,
        S_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic scan_step;
        logic clock_step;
        logic apply;
    } cmd_t;

    typedef struct packed {
        logic scan_last;
        logic found_hit;
        logic need_clock;
        logic clock_found;
        logic clock_none;
    } stat_t;

endpackage

[hdl/pfpr_datapath.sv]
// Datapath of the page frame pool: frame table, scan pointer, victim trackers, clock hand.
// Depends on pfpr_pkg; driven by pfpr_ctrl commands.
module pfpr_datapath
    import pfpr_pkg::*;
#(
    parameter int NUM_FRAMES = NUM_FRAMES_DEF,
    parameter int PAGE_BITS  = PAGE_BITS_DEF,
    parameter int FILE_BITS  = FILE_BITS_DEF,
    localparam int IW = $clog2(NUM_FRAMES),
    localparam int NW = $clog2(NUM_FRAMES + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cmd_t                 cmd,
    output stat_t                stat,
    input  logic [1:0]           mode,
    input  logic [NW-1:0]        n_act,
    input  logic [1:0]           action,
    input  logic [PAGE_BITS-1:0] page_num,
    input  logic [FILE_BITS-1:0] file_id,
    output logic [2:0]           res_status,
    output logic [IW-1:0]        res_frame,
    output logic                 res_fetch,
    output logic                 res_ev,
    output logic                 res_wb,
    output logic [PAGE_BITS-1:0] res_ev_page,
    output logic [FILE_BITS-1:0] res_ev_file
);

    logic [NUM_FRAMES-1:0] valid_reg, dirty_reg, use_reg;
    logic [7:0]            pin_reg   [NUM_FRAMES];
    logic [31:0]           stamp_reg [NUM_FRAMES];
    logic [PAGE_BITS-1:0]  page_reg  [NUM_FRAMES];
    logic [FILE_BITS-1:0]  file_reg  [NUM_FRAMES];
    logic [31:0]           ctr_reg;
    logic [IW-1:0]         hand_reg;
    logic [NW:0]           steps_reg;

    logic [1:0]            act_reg;
    logic [PAGE_BITS-1:0]  rpage_reg;
    logic [FILE_BITS-1:0]  rfile_reg;
    logic [IW-1:0]         idx_reg;
    logic                  hit_reg, free_reg, unp_reg;
    logic [IW-1:0]         hit_idx_reg, free_idx_reg, best_idx_reg;
    logic [31:0]           best_stamp_reg;
    logic                  victim_reg;
    logic [IW-1:0]         victim_idx_reg;

    logic [IW-1:0] n_last;
    logic          cur_unp, better;
    assign n_last  = IW'(n_act - NW'(1));
    assign cur_unp = (pin_reg[idx_reg] == 8'd0);
    assign better  = !unp_reg ||
                     ((mode == MODE_MRU) ? stamp_reg[idx_reg] > best_stamp_reg
                                         : stamp_reg[idx_reg] < best_stamp_reg);

    logic [IW-1:0] hand_eff;
    assign hand_eff = ({1'b0, hand_reg} >= (IW+1)'(n_act)) ? '0 : hand_reg;

    assign stat.scan_last   = (idx_reg == n_last);
    assign stat.found_hit   = hit_reg;
    assign stat.need_clock  = (mode == MODE_CLOCK) && (act_reg == ACT_PIN) && !free_reg;
    assign stat.clock_found = (pin_reg[hand_eff] == 8'd0) && !use_reg[hand_eff];
    assign stat.clock_none  = !unp_reg ||
                              (steps_reg == (NW+1)'({n_act, 1'b0}));

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            act_reg   <= action;
            rpage_reg <= page_num;
            rfile_reg <= file_id;
        end
        if (cmd.clock_step && stat.clock_found && !stat.clock_none)
            victim_idx_reg <= hand_eff;
        if (cmd.scan_step)
        begin
            if (valid_reg[idx_reg] && page_reg[idx_reg] == rpage_reg &&
                file_reg[idx_reg] == rfile_reg && !hit_reg)
                hit_idx_reg <= idx_reg;
            if (!valid_reg[idx_reg] && !free_reg)
                free_idx_reg <= idx_reg;
            if (cur_unp && better)
            begin
                best_idx_reg   <= idx_reg;
                best_stamp_reg <= stamp_reg[idx_reg];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            dirty_reg  <= '0;
            use_reg    <= '0;
            ctr_reg    <= '0;
            hand_reg   <= '0;
            idx_reg    <= '0;
            steps_reg  <= '0;
            hit_reg    <= 1'b0;
            free_reg   <= 1'b0;
            unp_reg    <= 1'b0;
            victim_reg <= 1'b0;
            res_status <= ST_ABSENT;
            res_frame  <= '0;
            res_fetch  <= 1'b0;
            res_ev     <= 1'b0;
            res_wb     <= 1'b0;
            res_ev_page <= '0;
            res_ev_file <= '0;
            for (int i = 0; i < NUM_FRAMES; i++)
            begin
                pin_reg[i]   <= '0;
                stamp_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.start)
            begin
                idx_reg    <= '0;
                steps_reg  <= '0;
                hit_reg    <= 1'b0;
                free_reg   <= 1'b0;
                unp_reg    <= 1'b0;
                victim_reg <= 1'b0;
            end
            if (cmd.scan_step)
            begin
                if (valid_reg[idx_reg] && page_reg[idx_reg] == rpage_reg &&
                    file_reg[idx_reg] == rfile_reg)
                    hit_reg <= 1'b1;
                if (!valid_reg[idx_reg])
                    free_reg <= 1'b1;
                if (cur_unp)
                    unp_reg <= 1'b1;
                idx_reg <= idx_reg + IW'(1);
            end
            if (cmd.clock_step && !stat.clock_none)
            begin
                hand_reg <= hand_eff;
                if (pin_reg[hand_eff] == 8'd0)
                begin
                    if (!use_reg[hand_eff])
                        victim_reg <= 1'b1;
                    else
                        use_reg[hand_eff] <= 1'b0;
                end
                if (!stat.clock_found)
                begin
                    hand_reg  <= hand_eff + IW'(1);
                    steps_reg <= steps_reg + (NW+1)'(1);
                end
            end
            if (cmd.apply)
            begin
                logic [IW-1:0] v;
                logic          have_v;
                res_status  <= ST_ABSENT;
                res_frame   <= '0;
                res_fetch   <= 1'b0;
                res_ev      <= 1'b0;
                res_wb      <= 1'b0;
                res_ev_page <= '0;
                res_ev_file <= '0;
                v      = free_reg ? free_idx_reg :
                         (mode == MODE_CLOCK) ? victim_idx_reg : best_idx_reg;
                have_v = free_reg ||
                         ((mode == MODE_CLOCK) ? victim_reg :
                          ((mode == MODE_LRU || mode == MODE_MRU) && unp_reg));
                if (act_reg == ACT_PIN)
                begin
                    if (hit_reg)
                    begin
                        if (pin_reg[hit_idx_reg] != 8'hFF)
                            pin_reg[hit_idx_reg] <= pin_reg[hit_idx_reg] + 8'd1;
                        stamp_reg[hit_idx_reg] <= ctr_reg;
                        use_reg[hit_idx_reg]   <= 1'b1;
                        ctr_reg    <= ctr_reg + 32'd1;
                        res_status <= ST_HIT;
                        res_frame  <= hit_idx_reg;
                    end
                    else if (!have_v)
                        res_status <= ST_PINNED;
                    else
                    begin
                        res_status <= free_reg ? ST_FREE : ST_EVICT;
                        res_frame  <= v;
                        res_fetch  <= 1'b1;
                        if (!free_reg)
                        begin
                            res_ev      <= 1'b1;
                            res_wb      <= dirty_reg[v];
                            res_ev_page <= page_reg[v];
                            res_ev_file <= file_reg[v];
                        end
                        valid_reg[v] <= 1'b1;
                        pin_reg[v]   <= 8'd1;
                        dirty_reg[v] <= 1'b0;
                        use_reg[v]   <= 1'b1;
                        stamp_reg[v] <= ctr_reg;
                        ctr_reg      <= ctr_reg + 32'd1;
                    end
                end
                else if ((act_reg == ACT_UNPIN || act_reg == ACT_DIRTY) && hit_reg)
                begin
                    res_status <= ST_DONE;
                    res_frame  <= hit_idx_reg;
                    if (act_reg == ACT_UNPIN)
                    begin
                        if (pin_reg[hit_idx_reg] != 8'd0)
                            pin_reg[hit_idx_reg] <= pin_reg[hit_idx_reg] - 8'd1;
                    end
                    else
                        dirty_reg[hit_idx_reg] <= 1'b1;
                end
            end
        end
    end

    // Tags are written only on a load.
    always_ff @(posedge clk)
    begin
        if (cmd.apply && act_reg == ACT_PIN && !hit_reg)
        begin
            logic [IW-1:0] v;
            logic          have_v;
            v      = free_reg ? free_idx_reg :
                     (mode == MODE_CLOCK) ? victim_idx_reg : best_idx_reg;
            have_v = free_reg ||
                     ((mode == MODE_CLOCK) ? victim_reg :
                      ((mode == MODE_LRU || mode == MODE_MRU) && unp_reg));
            if (have_v)
            begin
                page_reg[v] <= rpage_reg;
                file_reg[v] <= rfile_reg;
            end
        end
    end

    // A load must always leave the chosen frame pinned exactly once.
    a_load_pins: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.apply && (res_status != ST_HIT) ##0 1'b1 |=>
        ((res_status != ST_FREE && res_status != ST_EVICT) ||
         pin_reg[res_frame] == 8'd1))
        else $error("loaded frame not pinned once");
    // The clock search never runs past two sweeps.
    a_clock_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clock_step |-> steps_reg <= (NW+1)'({n_act, 1'b0}))
        else $error("clock search overran");
    // An eviction is always reported together with a fetch and the evict status.
    a_evict_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_ev) |-> res_fetch && res_status == ST_EVICT)
        else $error("eviction without fetch");

endmodule

[hdl/pfpr_ctrl.sv]
// Controller of the page frame pool: sequences scan, clock sweep, update and result.
// Depends on pfpr_pkg; commands pfpr_datapath.
module pfpr_ctrl
    import pfpr_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_fire,
    input  logic  out_fire,
    input  stat_t stat,
    output cmd_t  cmd,
    output logic  busy,
    output logic  out_pending
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_fire) state_next = S_SCAN;
            S_SCAN:
                if (stat.scan_last)
                    state_next = S_CLOCK;
            S_CLOCK:
                if (stat.found_hit || !stat.need_clock || stat.clock_none ||
                    stat.clock_found)
                    state_next = S_APPLY;
            S_APPLY: state_next = S_OUT;
            S_OUT:   if (out_fire) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            S_IDLE:  cmd.start = in_fire;
            S_SCAN:  cmd.scan_step = 1'b1;
            S_CLOCK: cmd.clock_step = !stat.found_hit && stat.need_clock;
            S_APPLY: cmd.apply = 1'b1;
            default: cmd = '0;
        endcase
    end

    assign busy        = (state_reg != S_IDLE);
    assign out_pending = (state_reg == S_OUT);

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.start, cmd.scan_step, cmd.clock_step, cmd.apply}))
        else $error("more than one command");
    a_out_after_apply: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.apply |=> out_pending)
        else $error("result not presented after update");
    a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_pending && !out_fire |=> out_pending)
        else $error("result dropped");

endmodule

[hdl/page_frame_pool_replacement.sv]
// Top level of the page frame pool with LRU, MRU and clock replacement.
// Depends on pfpr_pkg, pfpr_ctrl and pfpr_datapath.
//
// Each request (pin, unpin, mark dirty) is handled one at a time. The datapath walks the
// active frames once, one frame a cycle, looking for a tag hit, the lowest free frame and
// the least or most recently stamped unpinned frame. In clock mode, when a pin misses and
// no frame is free, the hand then sweeps one frame a cycle and finds its victim within
// twice the active frame count. The table is then updated and the result register loaded;
// the result waits in its register until taken. Configuration is written through the
// APB-style port: register 0 is the replacement mode, register 1 the active frame count.
module page_frame_pool_replacement
    import pfpr_pkg::*;
#(
    parameter int NUM_FRAMES = NUM_FRAMES_DEF,
    parameter int PAGE_BITS  = PAGE_BITS_DEF,
    parameter int FILE_BITS  = FILE_BITS_DEF,
    localparam int IW = $clog2(NUM_FRAMES),
    localparam int NW = $clog2(NUM_FRAMES + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           action,
    input  logic [PAGE_BITS-1:0] page_num,
    input  logic [FILE_BITS-1:0] file_id,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [2:0]           status,
    output logic [IW-1:0]        frame_index,
    output logic                 fetch_needed,
    output logic                 evicted_valid,
    output logic                 writeback_needed,
    output logic [PAGE_BITS-1:0] evicted_page,
    output logic [FILE_BITS-1:0] evicted_file
);

    logic [1:0]  mode_reg;
    logic [15:0] frames_reg;
    logic [NW-1:0] n_act;
    logic        busy, in_fire, out_fire;
    cmd_t        cmd;
    stat_t       stat;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_LRU;
            frames_reg <= 16'd16;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == REG_FRAMES[0])
                frames_reg <= pwdata[15:0];
            else
                mode_reg <= pwdata[1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_MODE[0])
            prdata[1:0] = mode_reg;
        else
            prdata[15:0] = frames_reg;
    end

    // Out-of-range frame counts are clamped to one and to the built size.
    always_comb
    begin
        if (frames_reg == 16'd0)
            n_act = NW'(1);
        else if (frames_reg > 16'(NUM_FRAMES))
            n_act = NW'(NUM_FRAMES);
        else
            n_act = NW'(frames_reg);
    end

    assign in_ready = !busy;
    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;

    pfpr_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_fire    (in_fire),
        .out_fire   (out_fire),
        .stat       (stat),
        .cmd        (cmd),
        .busy       (busy),
        .out_pending(out_valid)
    );

    pfpr_datapath #(
        .NUM_FRAMES(NUM_FRAMES),
        .PAGE_BITS (PAGE_BITS),
        .FILE_BITS (FILE_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .mode       (mode_reg),
        .n_act      (n_act),
        .action     (action),
        .page_num   (page_num),
        .file_id    (file_id),
        .res_status (status),
        .res_frame  (frame_index),
        .res_fetch  (fetch_needed),
        .res_ev     (evicted_valid),
        .res_wb     (writeback_needed),
        .res_ev_page(evicted_page),
        .res_ev_file(evicted_file)
    );

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while result waits");
    a_frame_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ({1'b0, frame_index} < (IW+1)'(n_act)))
        else $error("frame index outside pool");
    a_fetch_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fetch_needed |-> (status == ST_FREE || status == ST_EVICT))
        else $error("fetch with wrong status");

endmodule

[bench/testbench.sv]
// Self-checking testbench for page_frame_pool_replacement: directed table, then random traffic.
// Depends on pfpr_pkg and the page_frame_pool_replacement RTL only.
module testbench;
    import pfpr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NF = 16;
    localparam int LIMIT_CYCLES = 400000;

    // Pool tags are kept to a small set in random traffic so that hits, unpins of
    // resident pages and evictions all happen often.
    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  frame;
        logic        fetch;
        logic        ev;
        logic        wb;
        logic [23:0] ev_page;
        logic [7:0]  ev_file;
    } pool_result_t;

    typedef struct {
        logic [1:0]  act;
        logic [23:0] page;
        logic [7:0]  file;
        bit          has_exp;
        pool_result_t exp;
    } directed_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [1:0] action = '0;
    logic [23:0] page_num = '0;
    logic [7:0] file_id = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [2:0] status;
    logic [3:0] frame_index;
    logic fetch_needed, evicted_valid, writeback_needed;
    logic [23:0] evicted_page;
    logic [7:0] evicted_file;

    page_frame_pool_replacement uut (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Predictor state: a private copy of the frame table and its configuration.
    logic        pool_valid [NF];
    logic [23:0] pool_page [NF];
    logic [7:0]  pool_file [NF];
    logic [7:0]  pool_pins [NF];
    logic        pool_dirty [NF];
    logic        pool_use [NF];
    logic [31:0] pool_stamp [NF];
    logic [31:0] stamp_now;
    int unsigned hand;
    logic [1:0]  cfg_mode;
    logic [4:0]  cfg_frames;

    pool_result_t expected_results[$];
    int mismatches = 0;
    int results_seen = 0;
    int cycles = 0;
    bit hold_rx = 1'b0;
    bit no_idle = 1'b0;

    function automatic int victim_by_stamp(int n, bit newest);
        int best;
        best = -1;
        for (int i = 0; i < n; i++)
        begin
            if (pool_pins[i] != 0) continue;
            if (best < 0 || (newest ? pool_stamp[i] > pool_stamp[best]
                                    : pool_stamp[i] < pool_stamp[best]))
                best = i;
        end
        return best;
    endfunction

    function automatic int victim_by_clock(int n);
        bit any;
        any = 1'b0;
        for (int i = 0; i < n; i++)
            if (pool_pins[i] == 0) any = 1'b1;
        if (!any) return -1;
        for (int s = 0; s <= 2 * n; s++)
        begin
            if (hand >= n) hand = 0;
            if (pool_pins[hand] == 0)
            begin
                if (!pool_use[hand]) return hand;
                pool_use[hand] = 1'b0;
            end
            hand++;
        end
        return -1;
    endfunction

    function automatic void stamp_frame(int i);
        pool_stamp[i] = stamp_now;
        stamp_now++;
        pool_use[i] = 1'b1;
    endfunction

    // Works out the result of one request and advances the predicted table.
    function automatic pool_result_t serve_request(logic [1:0] act, logic [23:0] pg,
                                                   logic [7:0] fl);
        pool_result_t r;
        int n, hit, v;
        r = '0;
        r.status = ST_ABSENT;
        n = (cfg_frames < 1) ? 1 : (cfg_frames > NF) ? NF : cfg_frames;
        hit = -1;
        for (int i = 0; i < n; i++)
            if (hit < 0 && pool_valid[i] && pool_page[i] == pg && pool_file[i] == fl)
                hit = i;
        if (act == ACT_PIN)
        begin
            if (hit >= 0)
            begin
                r.frame = 4'(hit);
                if (pool_pins[hit] != 8'hFF) pool_pins[hit]++;
                stamp_frame(hit);
                r.status = ST_HIT;
            end
            else
            begin
                v = -1;
                r.status = ST_FREE;
                for (int i = 0; i < n; i++)
                    if (v < 0 && !pool_valid[i]) v = i;
                if (v < 0)
                begin
                    r.status = ST_EVICT;
                    case (cfg_mode)
                        MODE_LRU:   v = victim_by_stamp(n, 1'b0);
                        MODE_CLOCK: v = victim_by_clock(n);
                        MODE_MRU:   v = victim_by_stamp(n, 1'b1);
                        default:    v = -1;
                    endcase
                end
                if (v < 0)
                    r.status = ST_PINNED;
                else
                begin
                    r.frame = 4'(v);
                    r.fetch = 1'b1;
                    if (r.status == ST_EVICT)
                    begin
                        r.ev = 1'b1;
                        r.wb = pool_dirty[v];
                        r.ev_page = pool_page[v];
                        r.ev_file = pool_file[v];
                    end
                    pool_valid[v] = 1'b1;
                    pool_page[v] = pg;
                    pool_file[v] = fl;
                    pool_pins[v] = 8'd1;
                    pool_dirty[v] = 1'b0;
                    stamp_frame(v);
                end
            end
        end
        else if ((act == ACT_UNPIN || act == ACT_DIRTY) && hit >= 0)
        begin
            r.frame = 4'(hit);
            if (act == ACT_UNPIN)
            begin
                if (pool_pins[hit] != 0) pool_pins[hit]--;
            end
            else
                pool_dirty[hit] = 1'b1;
            r.status = ST_DONE;
        end
        return r;
    endfunction

    // Timeout watchdog.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, expected_results.size());
            $display("testbench: errors");
            $finish;
        end
    end

    // Receiver: random back-pressure, long hold-off on request, checking on accept.
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            pool_result_t got;
            got = {status, frame_index, fetch_needed, evicted_valid, writeback_needed,
                   evicted_page, evicted_file};
            results_seen++;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
            end
            else
            begin
                pool_result_t exp;
                exp = expected_results.pop_front();
                if (got !== exp)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", exp, got);
                end
            end
        end
        out_ready <= !hold_rx && (no_idle || $urandom_range(99) >= 16);
    end

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        @(posedge clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // Stops offering items, waits for the pool to drain, then a few more cycles.
    task automatic drain_pool();
        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic set_pool(logic [1:0] mode, logic [4:0] frames);
        drain_pool();
        apb_write(3'(REG_MODE) << 2, 32'(mode));
        apb_write(3'(REG_FRAMES) << 2, 32'(frames));
        cfg_mode = mode;
        cfg_frames = frames;
    endtask

    // Offers one item and holds it until accepted; the prediction is queued on accept.
    // Valid is left high so that a following item can go out back to back.
    task automatic send_request(logic [1:0] act, logic [23:0] pg, logic [7:0] fl,
                                bit has_exp = 1'b0, pool_result_t exp = '0);
        pool_result_t pred;
        while (!no_idle && $urandom_range(99) < 16)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        page_num <= pg;
        file_id <= fl;
        do @(posedge clk); while (!in_ready);
        pred = serve_request(act, pg, fl);
        if (has_exp && pred !== exp)
        begin
            mismatches++;
            if (mismatches <= 10) $display("table row disagrees with predictor: %p", exp);
        end
        expected_results.push_back(has_exp ? exp : pred);
    endtask

    function automatic pool_result_t res(logic [2:0] st, logic [3:0] fr, bit f);
        pool_result_t r;
        r = '0;
        r.status = st;
        r.frame = fr;
        r.fetch = f;
        return r;
    endfunction

    directed_row_t table_rows[$];
    logic [23:0] tag_pages[8];
    logic [7:0] tag_files[8];

    initial
    begin
        for (int i = 0; i < NF; i++)
        begin
            pool_valid[i] = 0; pool_page[i] = 0; pool_file[i] = 0; pool_pins[i] = 0;
            pool_dirty[i] = 0; pool_use[i] = 0; pool_stamp[i] = 0;
        end
        stamp_now = 0;
        hand = 0;
        cfg_mode = MODE_LRU;
        cfg_frames = 5'd16;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part on a two-frame pool: extremes of tags, every action,
        // absent pages, the unknown action, all frames pinned and a dirty eviction.
        set_pool(MODE_LRU, 5'd2);
        table_rows = '{
            '{ACT_UNPIN, 24'h0, 8'h0, 1, res(ST_ABSENT, 0, 0)},
            '{ACT_DIRTY, 24'hFFFFFF, 8'hFF, 1, res(ST_ABSENT, 0, 0)},
            '{ACT_PIN, 24'h0, 8'h0, 1, res(ST_FREE, 0, 1)},
            '{ACT_PIN, 24'hFFFFFF, 8'hFF, 1, res(ST_FREE, 1, 1)},
            '{ACT_PIN, 24'h0, 8'h0, 1, res(ST_HIT, 0, 0)},
            '{ACT_PIN, 24'h123456, 8'h5A, 1, res(ST_PINNED, 0, 0)},
            '{2'd3, 24'h0, 8'h0, 1, res(ST_ABSENT, 0, 0)},
            '{ACT_UNPIN, 24'h0, 8'h0, 1, res(ST_DONE, 0, 0)},
            '{ACT_UNPIN, 24'h0, 8'h0, 1, res(ST_DONE, 0, 0)},
            '{ACT_UNPIN, 24'h0, 8'h0, 1, res(ST_DONE, 0, 0)},
            '{ACT_DIRTY, 24'h0, 8'h0, 1, res(ST_DONE, 0, 0)},
            '{ACT_UNPIN, 24'hFFFFFF, 8'hFF, 1, res(ST_DONE, 1, 0)},
            '{ACT_PIN, 24'hAAAAAA, 8'h55, 0, '0},
            '{ACT_PIN, 24'h555555, 8'hAA, 0, '0},
            '{ACT_DIRTY, 24'hFFFFFF, 8'hFF, 0, '0}
        };
        foreach (table_rows[k])
            send_request(table_rows[k].act, table_rows[k].page, table_rows[k].file,
                         table_rows[k].has_exp, table_rows[k].exp);

        // Saturate a pin count at its top.
        set_pool(MODE_MRU, 5'd1);
        for (int i = 0; i < 258; i++) send_request(ACT_PIN, 24'h000777, 8'h07);
        set_pool(2'd3, 5'd0);
        send_request(ACT_PIN, 24'h000001, 8'h01);
        set_pool(MODE_LRU, 5'd31);
        send_request(ACT_PIN, 24'h000002, 8'h02);

        // Random part: several settings, most items naming a small set of tags.
        for (int phase = 0; phase < 8; phase++)
        begin
            logic [1:0] mode;
            logic [4:0] frames;
            mode = (phase < 6) ? 2'(phase % 3) : 2'($urandom_range(3));
            frames = (phase == 0) ? 5'd16 : (phase == 1) ? 5'd1 : 5'($urandom_range(31));
            set_pool(mode, frames);
            no_idle = (phase == 3);
            for (int t = 0; t < 8; t++)
            begin
                tag_pages[t] = 24'($urandom);
                tag_files[t] = 8'($urandom);
            end
            if (phase == 4)
            begin
                hold_rx = 1'b1;
                fork
                    begin
                        repeat (300) @(posedge clk);
                        hold_rx = 1'b0;
                    end
                join_none
            end
            for (int i = 0; i < 115; i++)
            begin
                int t, roll;
                logic [1:0] act;
                t = $urandom_range(7);
                roll = $urandom_range(99);
                act = (roll < 50) ? ACT_PIN : (roll < 80) ? ACT_UNPIN :
                      (roll < 97) ? ACT_DIRTY : 2'd3;
                if ($urandom_range(9) == 0)
                    send_request(act, 24'($urandom), 8'($urandom));
                else
                    send_request(act, tag_pages[t], tag_files[t]);
            end
        end
        no_idle = 1'b0;

        drain_pool();
        $display("covered all actions and modes over %0d results, frame counts 0 to 31",
                 results_seen);
        if (mismatches == 0)
            $display("testbench: clean");
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("testbench: errors");
        end
        $finish;
    end
endmodule
